// ===== rtl/fpa_pkg.sv =====
package fpa_pkg;

    // Result kinds carried on m_tuser
    localparam logic [1:0] STATUS_PLACED    = 2'd0;
    localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
    localparam logic [1:0] STATUS_NO_BLOCK  = 2'd2;
    localparam logic [1:0] STATUS_LOADED    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_PARTITION_SCHEME = 2'd0;
    localparam logic [1:0] CFG_TOTAL_MEMORY     = 2'd1;
    localparam logic [1:0] CFG_BLOCK_SIZE       = 2'd2;
    localparam logic [1:0] CFG_PARTITION_COUNT  = 2'd3;

    // Width of the shared add/subtract unit operands
    localparam int ALU_W = 32;

    // Partition table control from the sequencer
    typedef struct packed {
        logic wr_en;     // load an entry, mark it free
        logic rd_en;     // read size and free flag, data next cycle
        logic clr_free;  // mark an entry taken
    } tab_ctl_t;

endpackage

// ===== rtl/fpa_part_table.sv =====
module fpa_part_table
    import fpa_pkg::*;
#(
    parameter int NUM_PARTITIONS = 16,
    parameter int SIZE_BITS      = 16,
    parameter int IW             = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tab_ctl_t             ctl,
    input  logic [IW-1:0]        wr_addr,
    input  logic [SIZE_BITS-1:0] wr_size,
    input  logic [IW-1:0]        rd_addr,
    input  logic [IW-1:0]        clr_addr,
    output logic [SIZE_BITS-1:0] rd_size,
    output logic                 rd_free
);

    // Sizes: plain RAM, no reset
    logic [SIZE_BITS-1:0] size_mem [NUM_PARTITIONS];
    logic [NUM_PARTITIONS-1:0] free_reg;
    logic [SIZE_BITS-1:0] rd_size_reg;
    logic rd_free_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            size_mem[wr_addr] <= wr_size;
        end
        if (ctl.rd_en) begin
            rd_size_reg <= size_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg    <= '0;
            rd_free_reg <= 1'b0;
        end else begin
            if (ctl.wr_en) begin
                free_reg[wr_addr] <= 1'b1;
            end else if (ctl.clr_free) begin
                free_reg[clr_addr] <= 1'b0;
            end
            if (ctl.rd_en) begin
                rd_free_reg <= free_reg[rd_addr];
            end
        end
    end

    assign rd_size = rd_size_reg;
    assign rd_free = rd_free_reg;

endmodule

// ===== rtl/fixed_partition_allocator.sv =====
// Fixed-partition memory allocator, first-fit placement.
// Input channel s_*: one transfer per item. s_tuser is the mode (0 loads a
// partition size, 1 places a process request). Result channel m_*: exactly
// one transfer per item, m_tuser carries the status. Config channel cfg_*:
// index and data, always ready; write only while the block is idle.
// Timing: the block takes one item at a time; s_tready is low while an item
// is worked on. An unequal-mode request reads the last partition, then walks
// the partitions in order through one table read port and one shared
// add/subtract unit, one partition per cycle. The same unit does the
// saturating waste accumulation. A finished result sits in the output
// register; the next item is accepted while it waits, and only the hand-off
// of that item's result waits on m_tready.
// Reset (aresetn low, synchronous) empties the pipeline, clears all
// partitions to not free, the equal-mode block pointer, the claimed memory
// and the waste total, and restores the register defaults. Partition sizes
// are not cleared; reads of unloaded entries are undefined.
module fixed_partition_allocator
    import fpa_pkg::*;
#(
    parameter int NUM_PARTITIONS = 16,
    parameter int SIZE_BITS      = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // mode
    input  logic        s_tuser,
    // entry_index[3:0], entry_size[19:4], process_id[35:20],
    // process_size[51:36], zero pad [55:52]
    input  logic [55:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // status[1:0]
    output logic [1:0]  m_tuser,
    // slot[3:0], owner[19:4], waste[35:20], total_waste[67:36], zero pad [71:68]
    output logic [71:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    localparam int IW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int CW = $clog2(NUM_PARTITIONS + 1);
    localparam int KW = (CW > 5) ? CW : 5;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_EQ_SIZE = 8'b0000_0010,
        ST_EQ_ROOM = 8'b0000_0100,
        ST_EQ_FIT  = 8'b0000_1000,
        ST_UQ_LAST = 8'b0001_0000,
        ST_UQ_SCAN = 8'b0010_0000,
        ST_ACC     = 8'b0100_0000,
        ST_FINISH  = 8'b1000_0000
    } state_t;

    // Input field unpack
    logic [3:0]  in_entry_index;
    logic [15:0] in_entry_size;
    logic [15:0] in_process_id;
    logic [15:0] in_process_size;
    assign in_entry_index  = s_tdata[3:0];
    assign in_entry_size   = s_tdata[19:4];
    assign in_process_id   = s_tdata[35:20];
    assign in_process_size = s_tdata[51:36];

    // Config registers
    logic        scheme_reg;
    logic [15:0] total_memory_reg;
    logic [15:0] block_size_reg;
    logic [4:0]  partition_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scheme_reg          <= 1'b0;
            total_memory_reg    <= 16'd0;
            block_size_reg      <= 16'd1;
            partition_count_reg <= 5'd16;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                CFG_PARTITION_SCHEME: scheme_reg          <= cfg_data[0];
                CFG_TOTAL_MEMORY:     total_memory_reg    <= cfg_data;
                CFG_BLOCK_SIZE:       block_size_reg      <= cfg_data;
                CFG_PARTITION_COUNT:  partition_count_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Sequencer state and working registers
    state_t        state_reg, state_next;
    logic [15:0]   pid_reg, pid_next;
    logic [15:0]   psize_reg, psize_next;
    logic [1:0]    status_reg, status_next;
    logic [3:0]    slot_reg, slot_next;
    logic [31:0]   waste_reg, waste_next;
    logic [16:0]   sum_reg, sum_next;          // claimed + block_size
    logic [IW-1:0] scan_idx_reg, scan_idx_next;
    logic [IW-1:0] last_idx_reg, last_idx_next;
    logic [CW-1:0] next_slot_reg, next_slot_next;
    logic [15:0]   claimed_reg, claimed_next;
    logic [31:0]   waste_total_reg, waste_total_next;

    // Output register
    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_status_reg, m_status_next;
    logic [67:0]   m_data_reg, m_data_next;

    // Shared add/subtract unit; on subtract, carry set means a >= b
    logic [ALU_W-1:0] alu_a, alu_b;
    logic             alu_sub;
    logic [ALU_W:0]   alu_res;
    logic             alu_carry;

    assign alu_res   = {1'b0, alu_a} + {1'b0, alu_b ^ {ALU_W{alu_sub}}}
                       + {{ALU_W{1'b0}}, alu_sub};
    assign alu_carry = alu_res[ALU_W];

    // Partition table
    tab_ctl_t             tab_ctl;
    logic [IW-1:0]        tab_wr_addr, tab_rd_addr;
    logic [SIZE_BITS-1:0] tab_wr_size, tab_rd_size;
    logic                 tab_rd_free;
    logic [31:0]          entry_size_ext;

    assign entry_size_ext = 32'(in_entry_size);
    assign tab_wr_size    = entry_size_ext[SIZE_BITS-1:0];
    assign tab_wr_addr    = IW'(in_entry_index);

    fpa_part_table #(
        .NUM_PARTITIONS (NUM_PARTITIONS),
        .SIZE_BITS      (SIZE_BITS),
        .IW             (IW)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (tab_ctl),
        .wr_addr  (tab_wr_addr),
        .wr_size  (tab_wr_size),
        .rd_addr  (tab_rd_addr),
        .clr_addr (scan_idx_reg),
        .rd_size  (tab_rd_size),
        .rd_free  (tab_rd_free)
    );

    // Partitions in use, clamped to the table
    logic [KW-1:0] cnt_raw, cnt_max, cnt_use;
    assign cnt_raw = KW'(partition_count_reg);
    assign cnt_max = KW'(NUM_PARTITIONS);
    assign cnt_use = (cnt_raw > cnt_max) ? cnt_max : cnt_raw;

    logic in_accept, out_accept, idx_in_range, eq_full;
    assign s_tready     = (state_reg == ST_IDLE);
    assign in_accept    = s_tvalid && s_tready;
    assign out_accept   = m_valid_reg && m_tready;
    assign idx_in_range = (32'(in_entry_index) < NUM_PARTITIONS);
    assign eq_full      = (next_slot_reg == CW'(NUM_PARTITIONS));

    always_comb begin
        state_next       = state_reg;
        pid_next         = pid_reg;
        psize_next       = psize_reg;
        status_next      = status_reg;
        slot_next        = slot_reg;
        waste_next       = waste_reg;
        sum_next         = sum_reg;
        scan_idx_next    = scan_idx_reg;
        last_idx_next    = last_idx_reg;
        next_slot_next   = next_slot_reg;
        claimed_next     = claimed_reg;
        waste_total_next = waste_total_reg;
        m_valid_next     = out_accept ? 1'b0 : m_valid_reg;
        m_status_next    = m_status_reg;
        m_data_next      = m_data_reg;
        tab_ctl          = '0;
        tab_rd_addr      = scan_idx_reg;
        alu_a            = waste_total_reg;
        alu_b            = waste_reg;
        alu_sub          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    pid_next    = in_process_id;
                    psize_next  = in_process_size;
                    status_next = STATUS_PLACED;
                    slot_next   = 4'd0;
                    waste_next  = 32'd0;
                    if (!s_tuser) begin
                        tab_ctl.wr_en = idx_in_range;
                        status_next   = STATUS_LOADED;
                        slot_next     = in_entry_index;
                        state_next    = ST_FINISH;
                    end else if (!scheme_reg) begin
                        state_next = ST_EQ_SIZE;
                    end else if (cnt_use == '0) begin
                        status_next = STATUS_NO_BLOCK;
                        state_next  = ST_FINISH;
                    end else begin
                        // fetch the last partition for the too-large test
                        last_idx_next = IW'(cnt_use - KW'(1));
                        tab_rd_addr   = IW'(cnt_use - KW'(1));
                        tab_ctl.rd_en = 1'b1;
                        state_next    = ST_UQ_LAST;
                    end
                end
            end
            ST_EQ_SIZE: begin
                alu_a   = 32'(block_size_reg);
                alu_b   = 32'(psize_reg);
                alu_sub = 1'b1;
                if (!alu_carry) begin
                    status_next = STATUS_TOO_LARGE;
                    state_next  = ST_FINISH;
                end else begin
                    waste_next = alu_res[31:0];
                    state_next = ST_EQ_ROOM;
                end
            end
            ST_EQ_ROOM: begin
                alu_a    = 32'(claimed_reg);
                alu_b    = 32'(block_size_reg);
                sum_next = alu_res[16:0];
                if (eq_full) begin
                    status_next = STATUS_NO_BLOCK;
                    waste_next  = 32'd0;
                    state_next  = ST_FINISH;
                end else begin
                    state_next = ST_EQ_FIT;
                end
            end
            ST_EQ_FIT: begin
                alu_a   = 32'(total_memory_reg);
                alu_b   = 32'(sum_reg);
                alu_sub = 1'b1;
                if (!alu_carry) begin
                    status_next = STATUS_NO_BLOCK;
                    waste_next  = 32'd0;
                    state_next  = ST_FINISH;
                end else begin
                    // sum fits under total_memory, so 16 bits hold it
                    slot_next      = 4'(next_slot_reg);
                    next_slot_next = next_slot_reg + CW'(1);
                    claimed_next   = sum_reg[15:0];
                    state_next     = ST_ACC;
                end
            end
            ST_UQ_LAST: begin
                alu_a   = 32'(tab_rd_size);
                alu_b   = 32'(psize_reg);
                alu_sub = 1'b1;
                if (!alu_carry) begin
                    status_next = STATUS_TOO_LARGE;
                    state_next  = ST_FINISH;
                end else begin
                    scan_idx_next = '0;
                    tab_rd_addr   = '0;
                    tab_ctl.rd_en = 1'b1;
                    state_next    = ST_UQ_SCAN;
                end
            end
            ST_UQ_SCAN: begin
                // read data belongs to scan_idx; next entry is fetched meanwhile
                alu_a   = 32'(tab_rd_size);
                alu_b   = 32'(psize_reg);
                alu_sub = 1'b1;
                if (tab_rd_free && alu_carry) begin
                    tab_ctl.clr_free = 1'b1;
                    slot_next        = 4'(scan_idx_reg);
                    waste_next       = alu_res[31:0];
                    state_next       = ST_ACC;
                end else if (scan_idx_reg == last_idx_reg) begin
                    status_next = STATUS_NO_BLOCK;
                    state_next  = ST_FINISH;
                end else begin
                    scan_idx_next = scan_idx_reg + IW'(1);
                    tab_rd_addr   = scan_idx_reg + IW'(1);
                    tab_ctl.rd_en = 1'b1;
                end
            end
            ST_ACC: begin
                // saturating accumulate, carry out means overflow
                waste_total_next = alu_res[ALU_W] ? '1 : alu_res[31:0];
                state_next       = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_data_next   = {waste_total_reg, waste_reg[15:0], pid_reg, slot_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            next_slot_reg   <= '0;
            claimed_reg     <= '0;
            waste_total_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            next_slot_reg   <= next_slot_next;
            claimed_reg     <= claimed_next;
            waste_total_reg <= waste_total_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pid_reg      <= pid_next;
        psize_reg    <= psize_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        waste_reg    <= waste_next;
        sum_reg      <= sum_next;
        scan_idx_reg <= scan_idx_next;
        last_idx_reg <= last_idx_next;
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {4'd0, m_data_reg};

    // Block pointer never passes the table
    a_next_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(next_slot_reg) <= NUM_PARTITIONS)
        else $error("equal-mode block pointer beyond table");

    // Waste total only grows while out of reset
    a_waste_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> waste_total_reg >= $past(waste_total_reg))
        else $error("waste total decreased");

    // A new result appears only from the finish step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result raised outside finish step");

    // Scan never walks past the last partition in use
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UQ_SCAN |-> scan_idx_reg <= last_idx_reg)
        else $error("partition scan out of range");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

// Testbench for fixed_partition_allocator.
// A predictor inside the bench follows the allocator item by item: the equal
// block pointer, claimed memory, partition table and saturating waste total.
// Each accepted input pushes one expected result. The checker pops it when
// the matching result transfer is seen on the m_ side.
// Sequence:
// - fill the table
// - directed equal-mode and first-fit cases
// - random traffic under four pacing phases
// - the equal-mode table bound
// - repeated full-size placements that add the largest waste per item
module tb;
    import fpa_pkg::*;

    localparam int NUM_PART      = 16;
    localparam int SETTLE_CYCLES = 40;   // well past the longest scan
    localparam int MAX_REPORTS   = 200;  // keeps a broken run's log readable

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [15:0] owner;
        logic [15:0] waste;
        logic [31:0] total_waste;
    } alloc_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tuser;
    logic [55:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  m_tuser;
    logic [71:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_data;

    fixed_partition_allocator uut (.*);

    // Predictor copy of the allocator's registers and state
    logic        alloc_scheme;
    logic [15:0] mem_total;
    logic [15:0] blk_size;
    logic [4:0]  part_count;
    logic [15:0] part_size [NUM_PART];
    logic        part_free [NUM_PART];
    logic [4:0]  next_block;
    logic [16:0] claimed;
    logic [31:0] waste_sum;

    alloc_result_t pending_results[$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int items_sent;
    int cfg_rounds;
    int status_seen [4];

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Receiver: random back-pressure, rate set per phase
    always @(posedge aclk) m_tready <= (int'($urandom_range(99)) >= recv_stall_pct);

    // Works out the result of one item and advances the predicted state.
    function automatic alloc_result_t predict_allocation(input logic mode,
                                                         input logic [3:0] eidx,
                                                         input logic [15:0] esize,
                                                         input logic [15:0] pid,
                                                         input logic [15:0] psize);
        alloc_result_t r;
        int            cnt;
        logic [32:0]   sum;
        r       = '0;
        r.owner = pid;
        cnt     = (part_count > NUM_PART) ? NUM_PART : int'(part_count);
        if (mode == 1'b0) begin
            // a load overwrites the entry and frees it, in either scheme
            part_size[eidx] = esize;
            part_free[eidx] = 1'b1;
            r.status        = STATUS_LOADED;
            r.slot          = eidx;
        end else if (alloc_scheme == 1'b0) begin
            // size check comes ahead of the fullness check
            if (psize > blk_size) begin
                r.status = STATUS_TOO_LARGE;
            end else if (next_block >= NUM_PART ||
                         int'(claimed) + int'(blk_size) > int'(mem_total)) begin
                r.status = STATUS_NO_BLOCK;
            end else begin
                r.status   = STATUS_PLACED;
                r.slot     = next_block[3:0];
                r.waste    = blk_size - psize;
                next_block = next_block + 5'd1;
                claimed    = claimed + blk_size;
            end
        end else if (cnt == 0) begin
            r.status = STATUS_NO_BLOCK;
        end else if (psize > part_size[cnt-1]) begin
            r.status = STATUS_TOO_LARGE;
        end else begin
            r.status = STATUS_NO_BLOCK;
            for (int i = 0; i < cnt; i++) begin
                if (part_free[i] && psize <= part_size[i]) begin
                    part_free[i] = 1'b0;
                    r.status     = STATUS_PLACED;
                    r.slot       = 4'(i);
                    r.waste      = part_size[i] - psize;
                    break;
                end
            end
        end
        if (mode && r.status == STATUS_PLACED) begin
            sum       = {1'b0, waste_sum} + r.waste;
            waste_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        r.total_waste = waste_sum;
        return r;
    endfunction

    // One input transfer. s_tvalid stays high into the next item unless
    // an idle gap is drawn.
    task automatic send_item(input logic mode, input logic [3:0] eidx,
                             input logic [15:0] esize, input logic [15:0] pid,
                             input logic [15:0] psize);
        if (int'($urandom_range(99)) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (int'($urandom_range(99)) < send_idle_pct);
        end
        s_tuser  <= mode;
        s_tdata  <= {4'b0, psize, pid, esize, eidx};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_allocation(mode, eidx, esize, pid, psize));
        items_sent++;
    endtask

    // Stop sending and let every outstanding result drain.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Writes all four registers back to back.
    // Unused upper data bits are randomized and must be ignored.
    task automatic program_allocator(input logic scheme, input logic [15:0] total,
                                     input logic [15:0] bsize, input logic [4:0] count);
        logic [15:0] junk;
        logic [15:0] value [4];
        junk     = 16'($urandom);
        value[0] = {junk[15:1], scheme};
        value[1] = total;
        value[2] = bsize;
        value[3] = {junk[15:5], count};
        for (int k = 0; k < 4; k++) begin
            cfg_addr  <= 2'(k);
            cfg_data  <= value[k];
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
            case (2'(k))
                CFG_PARTITION_SCHEME: alloc_scheme = value[k][0];
                CFG_TOTAL_MEMORY:     mem_total    = value[k];
                CFG_BLOCK_SIZE:       blk_size     = value[k];
                CFG_PARTITION_COUNT:  part_count   = value[k][4:0];
            endcase
        end
        cfg_valid <= 1'b0;
        cfg_rounds++;
    endtask

    task automatic check_field(input string what, input logic [31:0] expected,
                               input logic [31:0] got);
        if (got !== expected) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, expected, got);
        end
    endtask

    // Result checker: every m_ transfer is matched to the oldest prediction.
    always @(posedge aclk) begin : result_check
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                check_field("unexpected result, tdata", 32'h0, m_tdata[31:0]);
                if (m_tdata[31:0] == 32'h0)
                    check_field("unexpected result, status", 32'hFFFF, {30'b0, m_tuser});
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_tuser));
                check_field("slot", 32'(want.slot), 32'(m_tdata[3:0]));
                check_field("owner", 32'(want.owner), 32'(m_tdata[19:4]));
                check_field("waste", 32'(want.waste), 32'(m_tdata[35:20]));
                check_field("total_waste", want.total_waste, m_tdata[67:36]);
                status_seen[m_tuser]++;
            end
        end
    end

    // Every entry gets a size, so no request can ever read an unloaded one.
    // Sizes: 0 at the bottom, 65535 at the top, i*1000 between.
    task automatic test_table_fill();
        logic [15:0] size_of;
        for (int i = 0; i < NUM_PART; i++) begin
            size_of = (i == 0) ? 16'd0 : (i == NUM_PART - 1) ? 16'hFFFF : 16'(i * 1000);
            send_item(1'b0, 4'(i), size_of, (i % 2) ? 16'hFFFF : 16'h0000, 16'(i * 3));
        end
    endtask

    task automatic test_equal_blocks();
        wait_idle();
        program_allocator(1'b0, 16'd10, 16'd4, 5'd16);
        send_item(1'b1, 4'h0, 16'h0000, 16'h1234, 16'd4);      // exact fit, no waste
        send_item(1'b1, 4'hF, 16'hFFFF, 16'hFFFF, 16'd0);      // empty request, waste 4
        send_item(1'b1, 4'h0, 16'h0000, 16'h0001, 16'd3);      // third block overruns memory
        send_item(1'b1, 4'h0, 16'h0000, 16'h0002, 16'hFFFF);   // too large beats full
        wait_idle();
        // zero block size: only empty requests fit
        program_allocator(1'b0, 16'hFFFF, 16'd0, 5'd16);
        send_item(1'b1, 4'h3, 16'h5A5A, 16'h0000, 16'd0);
        send_item(1'b1, 4'h3, 16'h5A5A, 16'h8001, 16'd1);
    endtask

    task automatic test_unequal_first_fit();
        wait_idle();
        program_allocator(1'b1, 16'd0, 16'd1, 5'd0);
        send_item(1'b1, 4'h0, 16'h0, 16'h0101, 16'd0);         // no partitions in use
        wait_idle();
        program_allocator(1'b1, 16'd0, 16'd1, 5'd20);          // count clamps to the table
        send_item(1'b1, 4'h0, 16'h0, 16'h0202, 16'hFFFF);      // only the top entry fits
        send_item(1'b1, 4'h0, 16'h0, 16'h0303, 16'hFFFF);      // not too large, no free entry fits
        wait_idle();
        program_allocator(1'b1, 16'd0, 16'd1, 5'd4);
        send_item(1'b1, 4'h0, 16'h0, 16'h0404, 16'd3001);      // above entry 3
        send_item(1'b1, 4'h0, 16'h0, 16'h0505, 16'd0);         // zero-size entry 0
        send_item(1'b1, 4'h0, 16'h0, 16'h0606, 16'd1500);      // skips entry 1, takes 2
        send_item(1'b1, 4'h0, 16'h0, 16'h0707, 16'd2500);      // entry 3
        send_item(1'b1, 4'h0, 16'h0, 16'h0808, 16'd1);         // first fit lands on 1
        send_item(1'b1, 4'h0, 16'h0, 16'h0909, 16'd0);         // all four taken
        send_item(1'b0, 4'h2, 16'd2000, 16'h0A0A, 16'd0);      // reload frees a taken entry
        send_item(1'b1, 4'h0, 16'h0, 16'h0B0B, 16'd10);
    endtask

    // Random configuration per round, then mostly well-formed traffic:
    // loads and requests sized to land on the table, plus some noise.
    task automatic test_random_traffic(input int rounds, input int items_per_round);
        int          pick;
        int          cnt;
        logic [4:0]  count;
        logic [15:0] bsize;
        logic [15:0] total;
        logic [15:0] pid;
        logic [15:0] psize;
        logic [15:0] esize;
        logic [3:0]  eidx;
        for (int r = 0; r < rounds; r++) begin
            pick  = $urandom_range(9);
            count = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd1 : (pick == 2) ? 5'd16 :
                    (pick == 3) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(16, 1));
            pick  = $urandom_range(9);
            bsize = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 : (pick == 2) ? 16'hFFFF :
                    (pick < 7) ? 16'($urandom_range(64, 1)) : 16'($urandom_range(65535, 1));
            pick  = $urandom_range(9);
            total = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                    (pick < 6) ? 16'($urandom_range(1024)) : 16'($urandom_range(65535));
            wait_idle();
            program_allocator(1'($urandom_range(1)), total, bsize, count);
            cnt = (part_count > NUM_PART) ? NUM_PART : int'(part_count);
            for (int n = 0; n < items_per_round; n++) begin
                pick = $urandom_range(99);
                pid  = 16'($urandom);
                if (pick < 8) begin
                    send_item(1'($urandom), 4'($urandom), 16'($urandom), pid, 16'($urandom));
                end else if (pick < (alloc_scheme ? 40 : 20)) begin
                    eidx  = (cnt > 0 && $urandom_range(9) < 7) ? 4'($urandom_range(cnt - 1))
                                                               : 4'($urandom_range(15));
                    esize = $urandom_range(1) ? 16'($urandom_range(4095)) : 16'($urandom);
                    send_item(1'b0, eidx, esize, pid, 16'($urandom));
                end else begin
                    pick = $urandom_range(99);
                    if (alloc_scheme)
                        psize = (pick < 60) ? 16'($urandom_range(4095)) :
                                (pick < 75) ? 16'd0 : 16'($urandom);
                    else
                        psize = (pick < 60) ? 16'($urandom_range(blk_size)) : 16'($urandom);
                    send_item(1'b1, 4'($urandom), 16'($urandom), pid, psize);
                end
            end
        end
    endtask

    // Zero block size never fills memory, so equal mode runs into the table bound.
    task automatic test_equal_table_bound();
        wait_idle();
        program_allocator(1'b0, 16'hFFFF, 16'd0, 5'd16);
        while (next_block < NUM_PART)
            send_item(1'b1, 4'($urandom), 16'($urandom), 16'($urandom), 16'd0);
        send_item(1'b1, 4'($urandom), 16'($urandom), 16'($urandom), 16'd0);
        send_item(1'b1, 4'($urandom), 16'($urandom), 16'($urandom), 16'd0);
    endtask

    // Reload entry 0 at full size and place a small request on it: close to
    // 65535 waste per pair, the largest step the total can take.
    task automatic test_waste_accumulation();
        wait_idle();
        program_allocator(1'b1, 16'd0, 16'd1, 5'd1);
        for (int i = 0; i < 4; i++) begin
            send_item(1'b0, 4'h0, 16'hFFFF, 16'($urandom), 16'($urandom));
            send_item(1'b1, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(9)));
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_addr       = CFG_PARTITION_SCHEME;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        items_sent     = 0;
        cfg_rounds     = 0;
        status_seen    = '{0, 0, 0, 0};
        // register defaults and cleared state after reset
        alloc_scheme   = 1'b0;
        mem_total      = 16'd0;
        blk_size       = 16'd1;
        part_count     = 5'd16;
        next_block     = '0;
        claimed        = '0;
        waste_sum      = '0;
        for (int i = 0; i < NUM_PART; i++) begin
            part_free[i] = 1'b0;
            part_size[i] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_table_fill();
        test_equal_blocks();
        test_unequal_first_fit();

        // pacing phases: free running, slow sender, slow receiver, both jittery
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random_traffic(8, 48);
        send_idle_pct = 88; recv_stall_pct = 0;  test_random_traffic(8, 48);
        send_idle_pct = 0;  recv_stall_pct = 88; test_random_traffic(8, 48);
        send_idle_pct = 19; recv_stall_pct = 19; test_random_traffic(8, 48);

        test_equal_table_bound();
        send_idle_pct = 0;  recv_stall_pct = 0;
        test_waste_accumulation();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Covered %0d items over %0d register settings and four pacing phases.",
                 items_sent, cfg_rounds);
        $display("Statuses seen: placed %0d, too large %0d, no block %0d, loaded %0d.",
                 status_seen[STATUS_PLACED], status_seen[STATUS_TOO_LARGE],
                 status_seen[STATUS_NO_BLOCK], status_seen[STATUS_LOADED]);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Run limit, many times the slowest legal run
    initial begin
        #(100_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fpa_pkg.sv
rtl/fpa_part_table.sv
rtl/fixed_partition_allocator.sv
bench/tb.sv
